// ===== design/lsj_pkg.sv =====
// Shared types, codes and arithmetic helpers for the leg slew limiter / jump sequencer.
`timescale 1ns / 1ps
package lsj_pkg;

  localparam int LEN_W   = 11;
  localparam int ANG_W   = 12;
  localparam int STEP_W  = 10;
  localparam int ASTEP_W = 11;
  localparam int ROLL_W  = 14;
  localparam int SPEED_W = 15;
  localparam int TICK_W  = 4;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 11;
  localparam int CALC_W  = 15;

  localparam logic [LEN_W-1:0] LEN_LAUNCH  = 11'd1350;
  localparam logic [LEN_W-1:0] LEN_PREPARE = 11'd1000;
  localparam logic [LEN_W-1:0] LEN_BUFFER  = 11'd550;

  localparam logic signed [16:0] TILT_LIMIT = 17'sd2000;

  localparam logic [TICK_W-1:0] LAUNCH_LAST_TICK  = 4'd5;
  localparam logic [TICK_W-1:0] PREPARE_LAST_TICK = 4'd8;
  localparam logic [TICK_W-1:0] JUMP_END_TICK     = 4'd15;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_LAUNCH  = 2'd0,
    PH_PREPARE = 2'd1,
    PH_BUFFER  = 2'd2
  } phase_t;

  localparam logic [IDX_W-1:0] REG_ROLL_ENABLE = 3'd0;
  localparam logic [IDX_W-1:0] REG_STEP_NORMAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEP_BUFFER = 3'd2;
  localparam logic [IDX_W-1:0] REG_ANGLE_STEP  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LENGTH_MIN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_LENGTH_MAX  = 3'd5;
  localparam logic [IDX_W-1:0] REG_LIFT_LIMIT  = 3'd6;

  typedef struct packed {
    logic               roll_enable;
    logic [STEP_W-1:0]  length_step_normal;
    logic [STEP_W-1:0]  length_step_buffer;
    logic [ASTEP_W-1:0] angle_step;
    logic [LEN_W-1:0]   length_min;
    logic [LEN_W-1:0]   length_max;
    logic [LEN_W-1:0]   lift_limit;
  } cfg_t;

  typedef struct packed {
    logic             jumping;
    phase_t           phase;
    logic [LEN_W-1:0] base_length;
  } seq_t;

  typedef struct packed {
    logic [LEN_W-1:0]        left_len;
    logic [LEN_W-1:0]        right_len;
    logic signed [ANG_W-1:0] tilt;
  } leg_t;

  // move cur toward tgt by at most step
  function automatic logic signed [CALC_W-1:0] slew(
    input logic signed [CALC_W-1:0] cur,
    input logic signed [CALC_W-1:0] tgt,
    input logic [ASTEP_W-1:0]       step
  );
    logic signed [CALC_W:0] d;
    logic signed [CALC_W:0] s;
    begin
      d = (CALC_W+1)'(tgt) - (CALC_W+1)'(cur);
      s = $signed({{(CALC_W+1-ASTEP_W){1'b0}}, step});
      if (d > s) d = s;
      if (d < -s) d = -s;
      slew = CALC_W'((CALC_W+1)'(cur) + d);
    end
  endfunction

  // lower bound first, upper bound last
  function automatic logic [LEN_W-1:0] clamp_len(
    input logic signed [CALC_W-1:0] x,
    input logic [LEN_W-1:0]         lo,
    input logic [LEN_W-1:0]         hi
  );
    logic signed [CALC_W-1:0] y;
    logic signed [CALC_W-1:0] lo_s;
    logic signed [CALC_W-1:0] hi_s;
    begin
      lo_s = $signed({{(CALC_W-LEN_W){1'b0}}, lo});
      hi_s = $signed({{(CALC_W-LEN_W){1'b0}}, hi});
      y = x;
      if (y < lo_s) y = lo_s;
      if (y > hi_s) y = hi_s;
      clamp_len = y[LEN_W-1:0];
    end
  endfunction

endpackage

// ===== design/lsj_ifs.sv =====
// Handshake channel interfaces: input word, result word, register write.
`timescale 1ns / 1ps
interface lsj_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            action;
  logic signed [lsj_pkg::ROLL_W-1:0]     roll_correction;
  logic signed [lsj_pkg::SPEED_W-1:0]    speed_loop_out;
  modport source (output valid, action, roll_correction, speed_loop_out, input ready);
  modport sink   (input valid, action, roll_correction, speed_loop_out, output ready);
endinterface

interface lsj_out_if;
  logic                                valid;
  logic                                ready;
  logic [lsj_pkg::LEN_W-1:0]           left_length;
  logic [lsj_pkg::LEN_W-1:0]           right_length;
  logic signed [lsj_pkg::ANG_W-1:0]    left_angle;
  logic signed [lsj_pkg::ANG_W-1:0]    right_angle;
  logic                                jump_active;
  logic [1:0]                          jump_phase;
  modport source (output valid, left_length, right_length, left_angle, right_angle,
                  jump_active, jump_phase, input ready);
  modport sink   (input valid, left_length, right_length, left_angle, right_angle,
                  jump_active, jump_phase, output ready);
endinterface

interface lsj_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lsj_pkg::IDX_W-1:0]     index;
  logic [lsj_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/lsj_cfg.sv =====
// Configuration register file.
`timescale 1ns / 1ps
module lsj_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [lsj_pkg::IDX_W-1:0]   wr_index,
  input  logic [lsj_pkg::CFG_W-1:0]   wr_data,
  output lsj_pkg::cfg_t               cfg
);

  lsj_pkg::cfg_t cfg_r;
  lsj_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        lsj_pkg::REG_ROLL_ENABLE: cfg_nxt.roll_enable = wr_data[0];
        lsj_pkg::REG_STEP_NORMAL:
          cfg_nxt.length_step_normal = wr_data[lsj_pkg::STEP_W-1:0];
        lsj_pkg::REG_STEP_BUFFER:
          cfg_nxt.length_step_buffer = wr_data[lsj_pkg::STEP_W-1:0];
        lsj_pkg::REG_ANGLE_STEP:  cfg_nxt.angle_step = wr_data[lsj_pkg::ASTEP_W-1:0];
        lsj_pkg::REG_LENGTH_MIN:  cfg_nxt.length_min = wr_data[lsj_pkg::LEN_W-1:0];
        lsj_pkg::REG_LENGTH_MAX:  cfg_nxt.length_max = wr_data[lsj_pkg::LEN_W-1:0];
        lsj_pkg::REG_LIFT_LIMIT:  cfg_nxt.lift_limit = wr_data[lsj_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.roll_enable        <= 1'b1;
      cfg_r.length_step_normal <= 10'd20;
      cfg_r.length_step_buffer <= 10'd20;
      cfg_r.angle_step         <= 11'd50;
      cfg_r.length_min         <= 11'd240;
      cfg_r.length_max         <= 11'd1450;
      cfg_r.lift_limit         <= 11'd850;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/lsj_seq.sv =====
// Jump sequencer: tick counter, phase and base leg length.
`timescale 1ns / 1ps
module lsj_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  lsj_pkg::action_t     action,
  output lsj_pkg::seq_t        seq_cur,
  output lsj_pkg::seq_t        seq_nxt
);

  logic                             jumping_r, jumping_nxt;
  logic [lsj_pkg::TICK_W-1:0]       ticks_r, ticks_nxt;
  lsj_pkg::phase_t                  phase_r, phase_nxt;
  logic [lsj_pkg::LEN_W-1:0]        base_r, base_nxt;
  logic [lsj_pkg::TICK_W-1:0]       tick_inc;

  assign tick_inc = ticks_r + 1'b1;

  always_comb begin
    jumping_nxt = jumping_r;
    ticks_nxt   = ticks_r;
    phase_nxt   = phase_r;
    base_nxt    = base_r;
    if (fire) begin
      case (action)
        lsj_pkg::ACT_START: jumping_nxt = 1'b1;
        lsj_pkg::ACT_TICK: begin
          if (jumping_r) begin
            if (tick_inc != '0 && tick_inc < lsj_pkg::JUMP_END_TICK) begin
              ticks_nxt = tick_inc;
              if (tick_inc <= lsj_pkg::LAUNCH_LAST_TICK) begin
                base_nxt  = lsj_pkg::LEN_LAUNCH;
                phase_nxt = lsj_pkg::PH_LAUNCH;
              end else if (tick_inc <= lsj_pkg::PREPARE_LAST_TICK) begin
                base_nxt  = lsj_pkg::LEN_PREPARE;
                phase_nxt = lsj_pkg::PH_PREPARE;
              end else begin
                base_nxt  = lsj_pkg::LEN_BUFFER;
                phase_nxt = lsj_pkg::PH_BUFFER;
              end
            end else begin
              jumping_nxt = 1'b0;
              ticks_nxt   = '0;
              phase_nxt   = lsj_pkg::PH_LAUNCH;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jumping_r <= 1'b0;
      ticks_r   <= '0;
      phase_r   <= lsj_pkg::PH_LAUNCH;
      base_r    <= lsj_pkg::LEN_BUFFER;
    end else begin
      jumping_r <= jumping_nxt;
      ticks_r   <= ticks_nxt;
      phase_r   <= phase_nxt;
      base_r    <= base_nxt;
    end
  end

  assign seq_cur = '{jumping: jumping_r, phase: phase_r, base_length: base_r};
  assign seq_nxt = '{jumping: jumping_nxt, phase: phase_nxt, base_length: base_nxt};

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !jumping_r |-> (ticks_r == '0 && phase_r == lsj_pkg::PH_LAUNCH))
    else $error("idle sequencer holds a tick count or phase");

  a_no_end_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ticks_r != lsj_pkg::JUMP_END_TICK)
    else $error("tick counter parked on end tick");

  a_buffer_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (jumping_r && ticks_r > lsj_pkg::PREPARE_LAST_TICK) |->
      (phase_r == lsj_pkg::PH_BUFFER && base_r == lsj_pkg::LEN_BUFFER))
    else $error("late ticks not in buffer phase");

  a_launch_len: assert property (@(posedge clk) disable iff (!rst_n)
    (jumping_r && ticks_r != '0 && ticks_r <= lsj_pkg::LAUNCH_LAST_TICK) |->
      base_r == lsj_pkg::LEN_LAUNCH)
    else $error("launch ticks without launch length");

endmodule

// ===== design/lsj_leg.sv =====
// Leg datapath: roll lift, tilt mapping, slew or pass-through, length clamp.
`timescale 1ns / 1ps
module lsj_leg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                upd,
  input  logic signed [lsj_pkg::ROLL_W-1:0]   roll,
  input  logic signed [lsj_pkg::SPEED_W-1:0]  speed,
  input  lsj_pkg::cfg_t                       cfg,
  input  lsj_pkg::seq_t                       seq,
  output lsj_pkg::leg_t                       leg_nxt
);

  localparam int CW = lsj_pkg::CALC_W;
  localparam int LW = lsj_pkg::LEN_W;
  localparam int AW = lsj_pkg::ANG_W;

  logic [LW-1:0]           len_l_r, len_l_nxt;
  logic [LW-1:0]           len_r_r, len_r_nxt;
  logic signed [AW-1:0]    tilt_r, tilt_nxt;
  logic                    first_r;

  logic                    roll_pos;
  logic [lsj_pkg::ROLL_W-1:0] roll_mag;
  logic [LW-1:0]           lift;
  logic                    apply;
  logic [LW:0]             dl, dr;
  logic signed [16:0]      tilt_raw;
  logic signed [AW-1:0]    tilt_tgt;
  logic signed [CW-1:0]    dl_s, dr_s, tilt_s;
  logic signed [CW-1:0]    cur_l, cur_r, cur_t;
  logic signed [CW-1:0]    new_l, new_r, new_t;
  logic                    slew_en;
  logic [lsj_pkg::ASTEP_W-1:0] len_step;

  assign roll_pos = !roll[lsj_pkg::ROLL_W-1] && (roll != '0);
  assign roll_mag = roll[lsj_pkg::ROLL_W-1] ? (~roll + 1'b1) : roll;
  assign lift     = (roll_mag > {3'b000, cfg.lift_limit}) ? cfg.lift_limit : roll_mag[LW-1:0];
  assign apply    = !seq.jumping && cfg.roll_enable;

  assign dl = {1'b0, seq.base_length} + ((apply && !roll_pos) ? {1'b0, lift} : '0);
  assign dr = {1'b0, seq.base_length} + ((apply && roll_pos) ? {1'b0, lift} : '0);

  // tilt target = -2 * speed, limited
  always_comb begin
    tilt_raw = -$signed({speed[lsj_pkg::SPEED_W-1], speed, 1'b0});
    if (tilt_raw > lsj_pkg::TILT_LIMIT) tilt_tgt = AW'(lsj_pkg::TILT_LIMIT);
    else if (tilt_raw < -lsj_pkg::TILT_LIMIT) tilt_tgt = AW'(-lsj_pkg::TILT_LIMIT);
    else tilt_tgt = tilt_raw[AW-1:0];
  end

  assign dl_s   = $signed({{(CW-LW-1){1'b0}}, dl});
  assign dr_s   = $signed({{(CW-LW-1){1'b0}}, dr});
  assign tilt_s = CW'(tilt_tgt);

  // first update starts from the targets
  assign cur_l = first_r ? dl_s : $signed({{(CW-LW){1'b0}}, len_l_r});
  assign cur_r = first_r ? dr_s : $signed({{(CW-LW){1'b0}}, len_r_r});
  assign cur_t = first_r ? tilt_s : CW'(tilt_r);

  assign slew_en  = !seq.jumping || seq.phase == lsj_pkg::PH_BUFFER;
  assign len_step = {1'b0, (seq.phase == lsj_pkg::PH_BUFFER) ? cfg.length_step_buffer
                                                             : cfg.length_step_normal};

  assign new_l = slew_en ? lsj_pkg::slew(cur_l, dl_s, len_step) : dl_s;
  assign new_r = slew_en ? lsj_pkg::slew(cur_r, dr_s, len_step) : dr_s;
  assign new_t = slew_en ? lsj_pkg::slew(cur_t, tilt_s, cfg.angle_step) : tilt_s;

  always_comb begin
    len_l_nxt = len_l_r;
    len_r_nxt = len_r_r;
    tilt_nxt  = tilt_r;
    if (upd) begin
      len_l_nxt = lsj_pkg::clamp_len(new_l, cfg.length_min, cfg.length_max);
      len_r_nxt = lsj_pkg::clamp_len(new_r, cfg.length_min, cfg.length_max);
      tilt_nxt  = new_t[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_l_r <= '0;
      len_r_r <= '0;
      tilt_r  <= '0;
      first_r <= 1'b1;
    end else begin
      len_l_r <= len_l_nxt;
      len_r_r <= len_r_nxt;
      tilt_r  <= tilt_nxt;
      if (upd) first_r <= 1'b0;
    end
  end

  assign leg_nxt = '{left_len: len_l_nxt, right_len: len_r_nxt, tilt: tilt_nxt};

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tilt_r <= AW'(lsj_pkg::TILT_LIMIT)) && (tilt_r >= AW'(-lsj_pkg::TILT_LIMIT)))
    else $error("held tilt out of range");

  a_zero_before_first: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> (len_l_r == '0 && len_r_r == '0 && tilt_r == '0))
    else $error("leg state moved before first update");

  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> !first_r)
    else $error("first-update flag survived an update");

endmodule

// ===== design/leg_slew_limiter_jump_sequencer.sv =====
// Top level: input register, sequencer and leg datapath, result register.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    action, roll_correction, speed_loop_out
//  out_ch   out  valid/ready    left/right_length, left/right_angle, jump_active, jump_phase
//  cfg_ch   in   valid/ready    index, data (ready always high)
//
// One word per cycle while out_ch does not stall; a taken word goes from the input register
// to the result register through one pass of the lift/tilt/slew/clamp logic.
// State updates in the same cycle as the result is registered, so words follow back to back.
// Reset is synchronous, active low; valid flags and state registers take their reset values and the
// first update then loads the leg state directly. A stalled result holds one word in the
// input register; in_ch.ready drops only while both stages are full and out_ch stalls.
`timescale 1ns / 1ps
module leg_slew_limiter_jump_sequencer (
  input  logic      clk,
  input  logic      rst_n,
  lsj_in_if.sink    in_ch,
  lsj_out_if.source out_ch,
  lsj_cfg_if.sink   cfg_ch
);

  logic                                   in_v_r, in_v_nxt;
  lsj_pkg::action_t                       act_r;
  logic signed [lsj_pkg::ROLL_W-1:0]      roll_r;
  logic signed [lsj_pkg::SPEED_W-1:0]     speed_r;
  logic                                   out_v_r, out_v_nxt;
  logic                                   fire;
  logic                                   in_take;

  lsj_pkg::cfg_t cfg;
  lsj_pkg::seq_t seq_cur, seq_nxt;
  lsj_pkg::leg_t leg_nxt;

  logic [lsj_pkg::LEN_W-1:0]        res_len_l_r, res_len_r_r;
  logic signed [lsj_pkg::ANG_W-1:0] res_ang_l_r, res_ang_r_r;
  logic                             res_jump_r;
  logic [1:0]                       res_phase_r;

  assign fire        = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || fire;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) in_v_nxt = 1'b1;
    else if (fire) in_v_nxt = 1'b0;
    out_v_nxt = out_v_r;
    if (fire) out_v_nxt = 1'b1;
    else if (out_ch.ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r   <= lsj_pkg::action_t'(in_ch.action);
      roll_r  <= in_ch.roll_correction;
      speed_r <= in_ch.speed_loop_out;
    end
  end

  lsj_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid && cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  lsj_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .action  (act_r),
    .seq_cur (seq_cur),
    .seq_nxt (seq_nxt)
  );

  lsj_leg u_leg (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (fire && act_r == lsj_pkg::ACT_UPDATE),
    .roll    (roll_r),
    .speed   (speed_r),
    .cfg     (cfg),
    .seq     (seq_cur),
    .leg_nxt (leg_nxt)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      res_len_l_r <= leg_nxt.left_len;
      res_len_r_r <= leg_nxt.right_len;
      res_ang_l_r <= leg_nxt.tilt;
      res_ang_r_r <= -leg_nxt.tilt;
      res_jump_r  <= seq_nxt.jumping;
      res_phase_r <= seq_nxt.phase;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.left_length  = res_len_l_r;
  assign out_ch.right_length = res_len_r_r;
  assign out_ch.left_angle   = res_ang_l_r;
  assign out_ch.right_angle  = res_ang_r_r;
  assign out_ch.jump_active  = res_jump_r;
  assign out_ch.jump_phase   = res_phase_r;

  a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(in_v_r))
    else $error("result appeared without a held word");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !fire) |=> in_v_r)
    else $error("held word lost without being processed");

  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (res_ang_r_r == -res_ang_l_r))
    else $error("right angle is not the mirror of left");

endmodule

// ===== sim/leg_slew_limiter_jump_sequencer_test.sv =====
// Testbench for leg_slew_limiter_jump_sequencer: random handshakes, self-checking leg state.
`timescale 1ns / 1ps

typedef struct {
  logic [lsj_pkg::LEN_W-1:0]        left_len;
  logic [lsj_pkg::LEN_W-1:0]        right_len;
  logic signed [lsj_pkg::ANG_W-1:0] left_ang;
  logic signed [lsj_pkg::ANG_W-1:0] right_ang;
  logic                             active;
  logic [1:0]                       phase;
} leg_word_t;

class leg_tracker;
  lsj_pkg::cfg_t                    cfg;
  logic [lsj_pkg::LEN_W-1:0]        base_len;
  bit                               jumping;
  logic [lsj_pkg::TICK_W-1:0]       ticks;
  lsj_pkg::phase_t                  phase;
  logic [lsj_pkg::LEN_W-1:0]        left_len;
  logic [lsj_pkg::LEN_W-1:0]        right_len;
  logic signed [lsj_pkg::ANG_W-1:0] left_tilt;
  logic signed [lsj_pkg::ANG_W-1:0] right_tilt;
  bit                               first_pass;
  leg_word_t                        expected_legs[$];
  int                               errors;

  function new();
    cfg = '{roll_enable: 1'b1, length_step_normal: 10'd20, length_step_buffer: 10'd20,
            angle_step: 11'd50, length_min: 11'd240, length_max: 11'd1450,
            lift_limit: 11'd850};
    base_len   = lsj_pkg::LEN_BUFFER;
    jumping    = 1'b0;
    ticks      = '0;
    phase      = lsj_pkg::PH_LAUNCH;
    left_len   = '0;
    right_len  = '0;
    left_tilt  = '0;
    right_tilt = '0;
    first_pass = 1'b1;
    errors     = 0;
  endfunction

  function int step_toward(int cur, int tgt, int step);
    int d;
    d = tgt - cur;
    if (d > step) d = step;
    if (d < -step) d = -step;
    return cur + d;
  endfunction

  function int fit_length(int x);
    if (x < int'(cfg.length_min)) x = int'(cfg.length_min);
    if (x > int'(cfg.length_max)) x = int'(cfg.length_max);
    return x;
  endfunction

  function void write_reg(logic [lsj_pkg::IDX_W-1:0] idx, logic [lsj_pkg::CFG_W-1:0] value);
    case (idx)
      lsj_pkg::REG_ROLL_ENABLE: cfg.roll_enable = value[0];
      lsj_pkg::REG_STEP_NORMAL: cfg.length_step_normal = value[lsj_pkg::STEP_W-1:0];
      lsj_pkg::REG_STEP_BUFFER: cfg.length_step_buffer = value[lsj_pkg::STEP_W-1:0];
      lsj_pkg::REG_ANGLE_STEP:  cfg.angle_step = value[lsj_pkg::ASTEP_W-1:0];
      lsj_pkg::REG_LENGTH_MIN:  cfg.length_min = value[lsj_pkg::LEN_W-1:0];
      lsj_pkg::REG_LENGTH_MAX:  cfg.length_max = value[lsj_pkg::LEN_W-1:0];
      lsj_pkg::REG_LIFT_LIMIT:  cfg.lift_limit = value[lsj_pkg::LEN_W-1:0];
      default: ;
    endcase
  endfunction

  function void note_word(lsj_pkg::action_t act, int roll, int speed);
    leg_word_t w;
    int dl, dr, tilt, lim, l, r, lt, rt, sp;
    case (act)
      lsj_pkg::ACT_START: jumping = 1'b1;
      lsj_pkg::ACT_TICK: if (jumping) begin
        ticks = ticks + 1'b1;
        if (ticks != lsj_pkg::JUMP_END_TICK && ticks != 0) begin
          if (ticks <= lsj_pkg::LAUNCH_LAST_TICK) begin
            base_len = lsj_pkg::LEN_LAUNCH;
            phase    = lsj_pkg::PH_LAUNCH;
          end else if (ticks <= lsj_pkg::PREPARE_LAST_TICK) begin
            base_len = lsj_pkg::LEN_PREPARE;
            phase    = lsj_pkg::PH_PREPARE;
          end else begin
            base_len = lsj_pkg::LEN_BUFFER;
            phase    = lsj_pkg::PH_BUFFER;
          end
        end else begin
          jumping = 1'b0;
          ticks   = '0;
          phase   = lsj_pkg::PH_LAUNCH;
        end
      end
      lsj_pkg::ACT_UPDATE: begin
        dl  = int'(base_len);
        dr  = int'(base_len);
        lim = int'(cfg.lift_limit);
        if (!jumping && cfg.roll_enable) begin
          if (roll > 0) dr += (roll > lim) ? lim : roll;
          else dl += (-roll > lim) ? lim : -roll;
        end
        tilt = -2 * speed;
        if (tilt > lsj_pkg::TILT_LIMIT) tilt = int'(lsj_pkg::TILT_LIMIT);
        if (tilt < -lsj_pkg::TILT_LIMIT) tilt = -int'(lsj_pkg::TILT_LIMIT);
        l  = int'(left_len);
        r  = int'(right_len);
        lt = int'(left_tilt);
        rt = int'(right_tilt);
        if (first_pass) begin
          l          = dl;
          r          = dr;
          lt         = tilt;
          rt         = tilt;
          first_pass = 1'b0;
        end
        if (!jumping || phase == lsj_pkg::PH_BUFFER) begin
          sp = (phase == lsj_pkg::PH_BUFFER) ? int'(cfg.length_step_buffer)
                                             : int'(cfg.length_step_normal);
          l  = step_toward(l, dl, sp);
          r  = step_toward(r, dr, sp);
          lt = step_toward(lt, tilt, int'(cfg.angle_step));
          rt = step_toward(rt, tilt, int'(cfg.angle_step));
        end else begin
          l  = dl;
          r  = dr;
          lt = tilt;
          rt = tilt;
        end
        left_len   = (lsj_pkg::LEN_W)'(fit_length(l));
        right_len  = (lsj_pkg::LEN_W)'(fit_length(r));
        left_tilt  = (lsj_pkg::ANG_W)'(lt);
        right_tilt = (lsj_pkg::ANG_W)'(rt);
      end
      default: ;
    endcase
    w.left_len  = left_len;
    w.right_len = right_len;
    w.left_ang  = left_tilt;
    w.right_ang = -right_tilt;
    w.active    = jumping;
    w.phase     = phase;
    expected_legs.push_back(w);
  endfunction

  function int pending();
    return expected_legs.size();
  endfunction

  task report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  task check_word(leg_word_t got);
    leg_word_t want;
    if (expected_legs.size() == 0) begin
      report("word with nothing expected", 1, 0);
      return;
    end
    want = expected_legs.pop_front();
    if (got.left_len !== want.left_len) report("left_length", got.left_len, want.left_len);
    if (got.right_len !== want.right_len)
      report("right_length", got.right_len, want.right_len);
    if (got.left_ang !== want.left_ang) report("left_angle", got.left_ang, want.left_ang);
    if (got.right_ang !== want.right_ang)
      report("right_angle", got.right_ang, want.right_ang);
    if (got.active !== want.active) report("jump_active", got.active, want.active);
    if (got.phase !== want.phase) report("jump_phase", got.phase, want.phase);
  endtask
endclass

module leg_slew_limiter_jump_sequencer_test;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 1750;
  localparam int PHASES       = 8;

  logic clk;
  logic rst_n;
  bit   calm;
  int   cycles;
  int   sent;

  leg_tracker tracker = new();

  lsj_in_if  in_ch();
  lsj_out_if out_ch();
  lsj_cfg_if cfg_ch();

  leg_slew_limiter_jump_sequencer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly in the working range, sometimes any code of the field
  function automatic int pick_value(int w, int span);
    int r;
    logic [31:0] raw;
    r   = $urandom_range(0, 9);
    raw = $urandom;
    if (r == 0) return int'(raw << (32 - w)) >>> (32 - w);
    if (r == 1) return raw[0] ? -(1 << (w - 1)) : (1 << (w - 1)) - 1;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic send(lsj_pkg::action_t act, int roll, int speed);
    int gap;
    gap = pick_gap();
    if ($urandom_range(0, 199) == 0) drain();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= act;
    in_ch.roll_correction <= (lsj_pkg::ROLL_W)'(roll);
    in_ch.speed_loop_out  <= (lsj_pkg::SPEED_W)'(speed);
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_word(act, roll, speed);
    if (act != lsj_pkg::ACT_NONE) sent++;
  endtask

  task automatic write_reg(logic [lsj_pkg::IDX_W-1:0] idx, logic [lsj_pkg::CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.write_reg(idx, value);
  endtask

  task automatic apply_config(lsj_pkg::cfg_t c, logic [lsj_pkg::CFG_W-1:0] junk);
    drain();
    repeat (4) @(posedge clk);
    write_reg(lsj_pkg::REG_ROLL_ENABLE, {junk[lsj_pkg::CFG_W-1:1], c.roll_enable});
    write_reg(lsj_pkg::REG_STEP_NORMAL,
              {junk[lsj_pkg::CFG_W-1:lsj_pkg::STEP_W], c.length_step_normal});
    write_reg(lsj_pkg::REG_STEP_BUFFER,
              {junk[lsj_pkg::CFG_W-1:lsj_pkg::STEP_W], c.length_step_buffer});
    write_reg(lsj_pkg::REG_ANGLE_STEP, c.angle_step);
    write_reg(lsj_pkg::REG_LENGTH_MIN, c.length_min);
    write_reg(lsj_pkg::REG_LENGTH_MAX, c.length_max);
    write_reg(lsj_pkg::REG_LIFT_LIMIT, c.lift_limit);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    leg_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.left_len  = out_ch.left_length;
      got.right_len = out_ch.right_length;
      got.left_ang  = out_ch.left_angle;
      got.right_ang = out_ch.right_angle;
      got.active    = out_ch.jump_active;
      got.phase     = out_ch.jump_phase;
      tracker.check_word(got);
    end
  end

  initial begin
    lsj_pkg::cfg_t c;
    int            quota;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.action          <= lsj_pkg::ACT_NONE;
    in_ch.roll_correction <= '0;
    in_ch.speed_loop_out  <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= lsj_pkg::REG_ROLL_ENABLE;
    cfg_ch.data           <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: idle tick, unused action, first update, roll and tilt extremes
    send(lsj_pkg::ACT_TICK, 0, 0);
    send(lsj_pkg::ACT_NONE, -(1 << (lsj_pkg::ROLL_W - 1)), (1 << (lsj_pkg::SPEED_W - 1)) - 1);
    send(lsj_pkg::ACT_UPDATE, (1 << (lsj_pkg::ROLL_W - 1)) - 1, -(1 << (lsj_pkg::SPEED_W - 1)));
    send(lsj_pkg::ACT_UPDATE, -(1 << (lsj_pkg::ROLL_W - 1)), (1 << (lsj_pkg::SPEED_W - 1)) - 1);
    send(lsj_pkg::ACT_UPDATE, 0, 0);
    drain();
    send(lsj_pkg::ACT_START, 0, 0);
    send(lsj_pkg::ACT_START, 1234, -321);
    send(lsj_pkg::ACT_UPDATE, -3000, 700);
    for (int t = 1; t <= int'(lsj_pkg::JUMP_END_TICK); t++) begin
      send(lsj_pkg::ACT_TICK, 0, 0);
      if (t == 1 || t == int'(lsj_pkg::LAUNCH_LAST_TICK) + 1 ||
          t == int'(lsj_pkg::PREPARE_LAST_TICK) + 1 || t == int'(lsj_pkg::JUMP_END_TICK))
        send(lsj_pkg::ACT_UPDATE, pick_value(lsj_pkg::ROLL_W, 5000),
             pick_value(lsj_pkg::SPEED_W, 10000));
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: c = '{1'b1, 10'd20, 10'd20, 11'd50, 11'd240, 11'd1450, 11'd850};
        1: c = '{1'b0, 10'd0, 10'd0, 11'd0, 11'd0, 11'd2047, 11'd0};
        2: c = '{1'b1, 10'd1023, 10'd1023, 11'd2047, 11'd0, 11'd2047, 11'd2047};
        3: c = '{1'b1, 10'd1, 10'd1, 11'd1, 11'd1500, 11'd600, 11'd2000};
        default: begin
          c.roll_enable        = 1'($urandom_range(0, 1));
          c.length_step_normal = (lsj_pkg::STEP_W)'($urandom_range(1, 1000));
          c.length_step_buffer = (lsj_pkg::STEP_W)'($urandom_range(1, 1000));
          c.angle_step         = (lsj_pkg::ASTEP_W)'($urandom_range(1, 2000));
          c.length_min         = (lsj_pkg::LEN_W)'($urandom_range(0, 800));
          c.length_max         = (lsj_pkg::LEN_W)'($urandom_range(1000, 2000));
          c.lift_limit         = (lsj_pkg::LEN_W)'($urandom_range(0, 2000));
        end
      endcase
      calm = (p == 2 || p == 5);
      apply_config(c, (p % 2) ? (lsj_pkg::CFG_W)'($urandom) : '0);
      quota = sent + RANDOM_WORDS / PHASES;
      while (sent < quota) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            send(lsj_pkg::ACT_START, pick_value(lsj_pkg::ROLL_W, 5000),
                 pick_value(lsj_pkg::SPEED_W, 10000));
            repeat ($urandom_range(13, 17)) begin
              repeat ($urandom_range(0, 4))
                send(lsj_pkg::ACT_UPDATE, pick_value(lsj_pkg::ROLL_W, 5000),
                     pick_value(lsj_pkg::SPEED_W, 10000));
              if ($urandom_range(0, 19) == 0)
                send(lsj_pkg::ACT_START, pick_value(lsj_pkg::ROLL_W, 5000),
                     pick_value(lsj_pkg::SPEED_W, 10000));
              send(lsj_pkg::ACT_TICK, pick_value(lsj_pkg::ROLL_W, 5000),
                   pick_value(lsj_pkg::SPEED_W, 10000));
            end
          end
          6, 7: repeat ($urandom_range(1, 12))
            send(lsj_pkg::ACT_UPDATE, pick_value(lsj_pkg::ROLL_W, 5000),
                 pick_value(lsj_pkg::SPEED_W, 10000));
          default: repeat ($urandom_range(1, 6))
            send(lsj_pkg::action_t'($urandom_range(0, 3)), pick_value(lsj_pkg::ROLL_W, 5000),
                 pick_value(lsj_pkg::SPEED_W, 10000));
        endcase
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (tracker.pending() != 0) tracker.report("words never delivered", 0, tracker.pending());
    if (tracker.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
design/lsj_pkg.sv
design/lsj_ifs.sv
design/lsj_cfg.sv
design/lsj_seq.sv
design/lsj_leg.sv
design/leg_slew_limiter_jump_sequencer.sv
sim/leg_slew_limiter_jump_sequencer_test.sv
